### src/mtk_pkg.sv
// Package for the Morse text keyer: symbol code type, code tables and lookup.
// No dependencies; imported by every module of the block.
package mtk_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned DUR_W  = 19;
  localparam int unsigned MARK_W = 6;
  localparam int unsigned LEN_W  = 3;

  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;
  localparam logic [7:0]        CHAR_SPACE = 8'h20;

  // Shift amounts for the duration unit: units = (1 << sh) - 1
  localparam logic [1:0] SH_ONE   = 2'd1;
  localparam logic [1:0] SH_THREE = 2'd2;
  localparam logic [1:0] SH_SEVEN = 2'd3;

  // Marks held left aligned, MSB sent first, 1 = dash
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [MARK_W-1:0] marks;
  } sym_t;

  // {len, bits right aligned}
  localparam logic [8:0] LETTER_TAB [26] = '{
    {3'd2, 6'd1},  {3'd4, 6'd8},  {3'd4, 6'd10}, {3'd3, 6'd4},  {3'd1, 6'd0},
    {3'd4, 6'd2},  {3'd3, 6'd6},  {3'd4, 6'd0},  {3'd2, 6'd0},  {3'd4, 6'd7},
    {3'd3, 6'd5},  {3'd4, 6'd4},  {3'd2, 6'd3},  {3'd2, 6'd2},  {3'd3, 6'd7},
    {3'd4, 6'd6},  {3'd4, 6'd13}, {3'd3, 6'd2},  {3'd3, 6'd0},  {3'd1, 6'd1},
    {3'd3, 6'd1},  {3'd4, 6'd1},  {3'd3, 6'd3},  {3'd4, 6'd9},  {3'd4, 6'd11},
    {3'd4, 6'd12}
  };

  localparam logic [8:0] DIGIT_TAB [10] = '{
    {3'd5, 6'd31}, {3'd5, 6'd15}, {3'd5, 6'd7},  {3'd5, 6'd3},  {3'd5, 6'd1},
    {3'd5, 6'd0},  {3'd5, 6'd16}, {3'd5, 6'd24}, {3'd5, 6'd28}, {3'd5, 6'd30}
  };

  localparam logic [8:0] COMMA_CODE  = {3'd6, 6'd51};
  localparam logic [8:0] PERIOD_CODE = {3'd6, 6'd21};

  function automatic sym_t lookup(input logic [7:0] c);
    logic [8:0]       raw;
    logic [7:0]       off;
    logic [LEN_W-1:0] amt;
    sym_t             s;
    raw = '0;
    off = '0;
    case (c) inside
      ["A":"Z"]: begin
        off = c - 8'h41;
        raw = LETTER_TAB[off[4:0]];
      end
      ["a":"z"]: begin
        off = c - 8'h61;
        raw = LETTER_TAB[off[4:0]];
      end
      ["0":"9"]: begin
        off = c - 8'h30;
        raw = DIGIT_TAB[off[3:0]];
      end
      8'h2C:   raw = COMMA_CODE;
      8'h2E:   raw = PERIOD_CODE;
      default: raw = '0;
    endcase
    amt     = 3'd6 - raw[8:6];
    s.len   = raw[8:6];
    s.marks = raw[5:0] << amt;
    return s;
  endfunction

endpackage

### src/mtk_dur.sv
// Segment duration unit: unit time times 1, 3 or 7 as a shift and subtract.
// Depends on mtk_pkg.
module mtk_dur
  import mtk_pkg::*;
(
  input  logic [UNIT_W-1:0] unit_ms,
  input  logic [1:0]        sh,
  output logic [DUR_W-1:0]  dur_ms
);

  logic [DUR_W-1:0] unit_ext;

  assign unit_ext = {{(DUR_W-UNIT_W){1'b0}}, unit_ms};
  assign dur_ms   = (unit_ext << sh) - unit_ext;

endmodule

### src/morse_text_keyer.sv
// Morse text keyer top level: input sequencer, shared duration unit, output register.
// Depends on mtk_pkg and mtk_dur.
//
// Usage:
//   in_*  : one ASCII byte per transfer (valid/ready).
//   out_* : one LED segment per transfer: on/off, duration in ms, and last
//           on the final segment of the byte.
//   cfg_* : cfg_we writes cfg_wdata to the unit time at once; write only
//           while the block is idle.
// A byte gives 0 to 12 segments. The first segment reaches the output
// register after the input transfer has loaded the sequencer phase; after
// that one segment per cycle while out_ready is high.
// The rate is set by the single shift-subtract duration unit, which serves
// one segment per cycle. in_ready is low while segments of a byte are still
// to be produced; it rises once the final one is in the output register,
// so the next byte can enter while that segment waits.
// A stalled receiver holds the output register and the sequencer waits.
// Reset: unit time 100 ms, word start (no leading gap for the first byte).
module morse_text_keyer
  import mtk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_led_on,
  output logic [DUR_W-1:0]  out_duration_ms,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [UNIT_W-1:0] cfg_wdata
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_MARK = 2'd2;
  localparam logic [1:0] PH_IGAP = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic              prev_space_r, prev_space_nxt;
  logic              gap_long_r, gap_long_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [MARK_W-1:0] marks_r, marks_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              led_r, led_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              last_r, last_nxt;

  sym_t              sym;
  logic              in_xfer;
  logic              emit;
  logic [1:0]        sh;
  logic [DUR_W-1:0]  dur_calc;
  logic [LEN_W-1:0]  rem_dec;

  assign in_ready = (phase_r == PH_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign emit     = (phase_r != PH_IDLE) && (!out_valid_r || out_ready);
  assign sym      = lookup(in_char_code);
  assign rem_dec  = rem_r - 3'd1;

  mtk_dur u_dur (
    .unit_ms (unit_r),
    .sh      (sh),
    .dur_ms  (dur_calc)
  );

  always_comb begin
    phase_nxt      = phase_r;
    prev_space_nxt = prev_space_r;
    gap_long_nxt   = gap_long_r;
    rem_nxt        = rem_r;
    marks_nxt      = marks_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    led_nxt        = led_r;
    dur_nxt        = dur_r;
    last_nxt       = last_r;
    sh             = SH_ONE;

    if (in_xfer) begin
      if (in_char_code == CHAR_SPACE) begin
        phase_nxt      = PH_GAP;
        gap_long_nxt   = 1'b1;
        rem_nxt        = '0;
        prev_space_nxt = 1'b1;
      end else begin
        gap_long_nxt   = 1'b0;
        rem_nxt        = sym.len;
        marks_nxt      = sym.marks;
        prev_space_nxt = 1'b0;
        if (!prev_space_r)
          phase_nxt = PH_GAP;
        else if (sym.len != '0)
          phase_nxt = PH_MARK;
        else
          phase_nxt = PH_IDLE;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      case (phase_r)
        PH_GAP: begin
          sh        = gap_long_r ? SH_SEVEN : SH_THREE;
          led_nxt   = 1'b0;
          last_nxt  = (rem_r == '0);
          phase_nxt = (rem_r == '0) ? PH_IDLE : PH_MARK;
        end
        PH_IGAP: begin
          sh        = SH_ONE;
          led_nxt   = 1'b0;
          last_nxt  = 1'b0;
          phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          sh        = marks_r[MARK_W-1] ? SH_THREE : SH_ONE;
          led_nxt   = 1'b1;
          last_nxt  = (rem_dec == '0);
          rem_nxt   = rem_dec;
          marks_nxt = marks_r << 1;
          phase_nxt = (rem_dec == '0) ? PH_IDLE : PH_IGAP;
        end
        default: begin
          sh        = SH_ONE;
          phase_nxt = PH_IDLE;
        end
      endcase
      dur_nxt = dur_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_space_r <= 1'b1;
      out_valid_r  <= 1'b0;
      unit_r       <= UNIT_RESET;
    end else begin
      phase_r      <= phase_nxt;
      prev_space_r <= prev_space_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we)
        unit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    gap_long_r <= gap_long_nxt;
    rem_r      <= rem_nxt;
    marks_r    <= marks_nxt;
    led_r      <= led_nxt;
    dur_r      <= dur_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = led_r;
  assign out_duration_ms = dur_r;
  assign out_last        = last_r;

endmodule

### src/mtk_checker.sv
// Port-level checker for the Morse text keyer, bound to the top level.
// Depends on mtk_pkg; keeps its own copy of the unit time from cfg writes.
module mtk_checker
  import mtk_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [7:0]        in_char_code,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_led_on,
  input logic [DUR_W-1:0]  out_duration_ms,
  input logic              out_last,
  input logic              cfg_we,
  input logic [UNIT_W-1:0] cfg_wdata
);

  logic [UNIT_W-1:0] unit_r;
  logic [DUR_W-1:0]  u1, u3, u7;

  always_ff @(posedge clk) begin
    if (!rst_n)
      unit_r <= UNIT_RESET;
    else if (cfg_we)
      unit_r <= cfg_wdata;
  end

  assign u1 = {{(DUR_W-UNIT_W){1'b0}}, unit_r};
  assign u3 = (u1 << 2) - u1;
  assign u7 = (u1 << 3) - u1;

  // a stalled segment holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_on)
      && $stable(out_duration_ms) && $stable(out_last))
    else $error("stalled output segment changed");

  // every segment lasts 1, 3 or 7 units; a 7-unit segment is always dark
  a_dur_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duration_ms == u1 || out_duration_ms == u3
      || (out_duration_ms == u7 && !out_led_on))
    else $error("illegal segment duration");

  // a space always yields a segment, so the block is busy right after it
  a_space_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char_code == CHAR_SPACE |=> !in_ready)
    else $error("space accepted without producing a segment");

  // segments of one byte follow back to back once one is taken
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a byte's segment burst");

endmodule

bind morse_text_keyer mtk_checker u_mtk_checker (.*);

### tb/tb_morse_text_keyer.sv
// Self-checking testbench for morse_text_keyer: feeds text bytes, predicts LED segments.
// Holds a small segment scoreboard class and the top module tb_morse_text_keyer.
// Depends on mtk_pkg and the RTL of the keyer.

typedef struct packed {
  logic                     led_on;
  logic [mtk_pkg::DUR_W-1:0] duration_ms;
  logic                     last;
} segment_t;

class keyer_scoreboard;
  localparam int unsigned DOT_UNITS        = 1;
  localparam int unsigned DASH_UNITS       = 3;
  localparam int unsigned MARK_GAP_UNITS   = 1;
  localparam int unsigned LETTER_GAP_UNITS = 3;
  localparam int unsigned WORD_GAP_UNITS   = 7;
  localparam int unsigned REPORT_LIMIT     = 10;

  segment_t                    segments_due[$];
  logic [mtk_pkg::UNIT_W-1:0] unit_ms;
  bit                          after_space;
  int unsigned                 failures;
  string                       letter_code[26];
  string                       digit_code[10];

  function new();
    unit_ms     = mtk_pkg::UNIT_RESET;
    after_space = 1'b1;
    failures    = 0;
    letter_code = '{"._", "_...", "_._.", "_..", ".", ".._.", "__.", "....", "..",
                    ".___", "_._", "._..", "__", "_.", "___", ".__.", "__._", "._.",
                    "...", "_", ".._", "..._", ".__", "_.._", "_.__", "__.."};
    digit_code  = '{"_____", ".____", "..___", "...__", "...._", ".....", "_....",
                    "__...", "___..", "____."};
  endfunction

  function void set_unit(logic [mtk_pkg::UNIT_W-1:0] value);
    unit_ms = value;
  endfunction

  function int pending();
    return segments_due.size();
  endfunction

  // Dots and dashes of a byte; empty for anything not in the code
  function string morse_pattern(logic [7:0] c);
    if (c >= "A" && c <= "Z") return letter_code[c - "A"];
    if (c >= "a" && c <= "z") return letter_code[c - "a"];
    if (c >= "0" && c <= "9") return digit_code[c - "0"];
    if (c == ",") return "__..__";
    if (c == ".") return "._._._";
    return "";
  endfunction

  function void push_segment(logic on, int unsigned units, logic last);
    segment_t s;
    s.led_on      = on;
    s.duration_ms = mtk_pkg::DUR_W'(int'(unit_ms) * units);
    s.last        = last;
    segments_due.push_back(s);
  endfunction

  // Called on every accepted input transfer
  function void note_char(logic [7:0] c);
    string       pat;
    int unsigned total;
    int unsigned idx;
    int unsigned k;
    if (c == mtk_pkg::CHAR_SPACE) begin
      push_segment(1'b0, WORD_GAP_UNITS, 1'b1);
      after_space = 1'b1;
      return;
    end
    pat   = morse_pattern(c);
    total = (after_space ? 0 : 1) + (pat.len() == 0 ? 0 : 2 * pat.len() - 1);
    idx   = 0;
    if (!after_space) begin
      idx++;
      push_segment(1'b0, LETTER_GAP_UNITS, idx == total);
    end
    after_space = 1'b0;
    for (k = 0; k < pat.len(); k++) begin
      if (k != 0) begin
        idx++;
        push_segment(1'b0, MARK_GAP_UNITS, idx == total);
      end
      idx++;
      push_segment(1'b1, (pat[k] == "_") ? DASH_UNITS : DOT_UNITS, idx == total);
    end
  endfunction

  // Called on every accepted result transfer
  function void check_segment(segment_t got);
    segment_t want;
    if (segments_due.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("unexpected segment: on=%0b dur=%0d last=%0b",
                 got.led_on, got.duration_ms, got.last);
      return;
    end
    want = segments_due.pop_front();
    if (got.led_on !== want.led_on || got.duration_ms !== want.duration_ms ||
        got.last !== want.last) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display({"segment mismatch: expected on=%0b dur=%0d last=%0b, ",
                  "got on=%0b dur=%0d last=%0b"},
                 want.led_on, want.duration_ms, want.last,
                 got.led_on, got.duration_ms, got.last);
    end
  endfunction
endclass

module tb_morse_text_keyer;
  timeunit 1ns;
  timeprecision 1ps;
  import mtk_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 20;
  localparam int unsigned RESET_TICKS  = 11;

  localparam logic [7:0] DIRECTED [20] = '{
    "A", "4", " ", " ", 8'h00, 8'hFF, "z", ",", ".", "0",
    "9", "Z", "a", 8'h80, " ", "E", "T", 8'h7F, "5", "Q"
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_char_code;
  logic              out_valid;
  logic              out_ready;
  logic              out_led_on;
  logic [DUR_W-1:0]  out_duration_ms;
  logic              out_last;
  logic              cfg_we;
  logic [UNIT_W-1:0] cfg_wdata;

  keyer_scoreboard sb;
  int unsigned     snd_idle;
  int unsigned     rcv_idle;
  int unsigned     cycle_count;

  morse_text_keyer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_on      (out_led_on),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_segment('{out_led_on, out_duration_ms, out_last});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic wait_segments_done();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Quiet spell before a unit time write
  task automatic settle_idle();
    wait_segments_done();
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_unit(input logic [UNIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_unit(value);
  endtask

  // Mostly plain text, with a share of arbitrary bytes
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return CHAR_SPACE;
    if (r < 40) return 8'("A" + $urandom_range(0, 25));
    if (r < 55) return 8'("a" + $urandom_range(0, 25));
    if (r < 70) return 8'("0" + $urandom_range(0, 9));
    if (r < 78) return ($urandom_range(0, 1) != 0) ? 8'(",") : 8'(".");
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_text(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i == count / 3 || $urandom_range(0, 99) == 0)
        wait_segments_done();
      send_char(pick_text_byte());
    end
  endtask

  initial begin
    int unsigned i;
    sb           = new();
    snd_idle     = 32;
    rcv_idle     = 45;
    cycle_count  = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    out_ready    <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 20; i++) send_char(DIRECTED[i]);

    settle_idle();
    write_unit(16'hFFFF);
    run_text(115);

    settle_idle();
    snd_idle = 45;
    rcv_idle = 32;
    write_unit(16'h0000);
    run_text(115);

    settle_idle();
    snd_idle = 0;
    rcv_idle = 0;
    write_unit(16'h0001);
    run_text(105);

    settle_idle();
    write_unit(16'($urandom_range(2, 65534)));
    run_text(105);

    settle_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
